>>> design/png_scanline_unfilter_argb_core_defines.svh
// Assertion macros shared by the PNG unfilter RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef PNG_SCANLINE_UNFILTER_ARGB_CORE_DEFINES_SVH
`define PNG_SCANLINE_UNFILTER_ARGB_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define PNGUF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PNGUF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/pnguf_pkg.sv
// Shared types, constants and the Paeth predictor for the PNG unfilter block.
// No dependencies; compile first.
package pnguf_pkg;

    localparam int DATA_W       = 8;
    localparam int ARGB_W       = 32;
    localparam int COORD_W      = 10;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 11;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 11;
    localparam int CHAN_REG_W   = 3;
    localparam int MAX_HEIGHT   = 1024;
    localparam int LANES        = 4;
    localparam logic [DATA_W-1:0] ALPHA_OPAQUE = 8'hFF;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH   = 2'd0,
        CFG_IMAGE_HEIGHT  = 2'd1,
        CFG_CHANNEL_COUNT = 2'd2
    } cfg_index_t;

    // Row filter types
    typedef enum logic [DATA_W-1:0] {
        FILTER_NONE    = 8'd0,
        FILTER_SUB     = 8'd1,
        FILTER_UP      = 8'd2,
        FILTER_AVERAGE = 8'd3,
        FILTER_PAETH   = 8'd4
    } filter_t;

    // Per-byte control carried into the reconstruct stage
    typedef struct packed {
        logic               first;
        logic               row_zero;
        logic               emit;
        logic               last;
        logic [1:0]         chan;
        logic [1:0]         ch_m1;
        logic [DATA_W-1:0]  filter;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } s1_ctrl_t;

    // Pick the neighbor closest to a + b - c, ties to a, then b
    function automatic logic [DATA_W-1:0] paeth_predict(
        input logic [DATA_W-1:0] a,
        input logic [DATA_W-1:0] b,
        input logic [DATA_W-1:0] c
    );
        logic signed [DATA_W+2:0] p;
        logic signed [DATA_W+2:0] da;
        logic signed [DATA_W+2:0] db;
        logic signed [DATA_W+2:0] dc;
        p  = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({3'b000, c});
        da = p - $signed({3'b000, a});
        db = p - $signed({3'b000, b});
        dc = p - $signed({3'b000, c});
        if (da < 0) da = -da;
        if (db < 0) db = -db;
        if (dc < 0) dc = -dc;
        if (da <= db && da <= dc) return a;
        if (db <= dc) return b;
        return c;
    endfunction

endpackage

>>> design/pnguf_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on pnguf_pkg.
interface pnguf_cfg_if;
    import pnguf_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> design/pnguf_in_if.sv
// Input byte channel: inflated scanline stream with frame start mark.
// Depends on pnguf_pkg.
interface pnguf_in_if;
    import pnguf_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              frame_start;

    modport source (output valid, data_byte, frame_start, input ready);
    modport sink   (input valid, data_byte, frame_start, output ready);
endinterface

>>> design/pnguf_out_if.sv
// Output pixel channel: ARGB32 pixel with its position and last mark.
// Depends on pnguf_pkg.
interface pnguf_out_if;
    import pnguf_pkg::*;

    logic               valid;
    logic               ready;
    logic [ARGB_W-1:0]  argb;
    logic [COORD_W-1:0] pixel_column;
    logic [COORD_W-1:0] pixel_row;
    logic               last_of_image;

    modport source (output valid, argb, pixel_column, pixel_row, last_of_image, input ready);
    modport sink   (input valid, argb, pixel_column, pixel_row, last_of_image, output ready);
endinterface

>>> design/png_scanline_unfilter_argb_core.sv
// PNG scanline unfilter top level: line store, reconstruct stage, pixel output register.
// Depends on pnguf_pkg, pnguf_cfg_if, pnguf_in_if, pnguf_out_if and the defines header.
//
//   channel       | role   | word contents                                  | handshake
//   cfg           | sink   | index (2b), data (11b)                         | valid/ready
//   byte_stream   | sink   | data_byte (8b), frame_start (1b)               | valid/ready
//   pixel_stream  | source | argb (32b), pixel_column, pixel_row, last mark | valid/ready
//
// One byte per cycle when not stalled: the line store read is issued when a byte is taken
// and reconstructed the next cycle; its pixel word is registered as its last byte leaves
// the stage. After reset the line store is cleared, all MAX_WIDTH*MAX_CHANNELS entries
// (4096 by default); byte_stream.ready stays low during the sweep, cfg writes are taken
// throughout. A pixel word waiting on pixel_stream holds the stage and then the input.
`include "png_scanline_unfilter_argb_core_defines.svh"

module png_scanline_unfilter_argb_core #(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_CHANNELS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    pnguf_cfg_if.sink   cfg,
    pnguf_in_if.sink    byte_stream,
    pnguf_out_if.source pixel_stream
);
    import pnguf_pkg::*;

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int BC_W        = $clog2(STORE_DEPTH + 1);
    localparam int CALC_W      = (BC_W + 2 > 16) ? BC_W + 2 : 16;
    localparam int PROD_W      = 2 * CALC_W;
    localparam int DIV_SHIFT   = BC_W + 1;
    localparam int DIV_MULT    = (2 ** DIV_SHIFT + 2) / 3;
    localparam int WIDTH_CAP   = (MAX_WIDTH > 2 ** WIDTH_REG_W - 1) ?
                                 2 ** WIDTH_REG_W - 1 : MAX_WIDTH;

    // Configuration registers
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [CHAN_REG_W-1:0]   chan_cnt_reg;

    // Position state
    logic [BC_W-1:0]    bc_reg, bc_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic               at_start_reg, at_start_next;
    logic [DATA_W-1:0]  filter_reg, filter_next;

    // Line store clearing sweep
    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;

    // Reconstruct stage
    logic              s1_valid_reg;
    s1_ctrl_t          s1_ctrl_reg;
    logic [DATA_W-1:0] s1_data_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic [DATA_W-1:0] left_reg  [LANES];
    logic [DATA_W-1:0] upper_reg [LANES];
    logic [23:0]       gather_reg, gather_next;

    // Output register
    logic               out_valid_reg;
    logic [ARGB_W-1:0]  out_argb_reg;
    logic [COORD_W-1:0] out_col_reg;
    logic [COORD_W-1:0] out_row_reg;
    logic               out_last_reg;

    logic [DATA_W-1:0] store_mem [STORE_DEPTH];

    // Combinational signals
    logic [WIDTH_REG_W-1:0]  eff_width;
    logic [HEIGHT_REG_W-1:0] eff_height;
    logic [CHAN_REG_W-1:0]   eff_ch;
    logic [BC_W-1:0]         line_len;
    logic                    in_fire, in_data, s1_fire;
    logic [BC_W-1:0]         bc_chk, bc_inc;
    logic [COORD_W-1:0]      row_chk, row_wrap;
    logic                    start_chk;
    logic [CALC_W-1:0]       bcx, q3, col;
    logic [PROD_W-1:0]       prod3;
    logic [1:0]              chan, ch_m1;
    logic [ADDR_W-1:0]       rd_addr;
    s1_ctrl_t                s1_ctrl_next;
    logic [DATA_W-1:0]       base_left  [LANES];
    logic [DATA_W-1:0]       base_upper [LANES];
    logic [23:0]             base_gather;
    logic [DATA_W-1:0]       nb_a, nb_b, nb_c, pred, rec;
    logic [ARGB_W-1:0]       argb_new;
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    logic [DATA_W-1:0]       mem_wdata;

    // Write configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_REG_W'(1);
            height_reg   <= HEIGHT_REG_W'(1);
            chan_cnt_reg <= CHAN_REG_W'(4);
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_IMAGE_WIDTH:   width_reg    <= cfg.data[WIDTH_REG_W-1:0];
                CFG_IMAGE_HEIGHT:  height_reg   <= cfg.data[HEIGHT_REG_W-1:0];
                CFG_CHANNEL_COUNT: chan_cnt_reg <= cfg.data[CHAN_REG_W-1:0];
                default:           ;
            endcase
        end
    end

    // Clamp registers to their working ranges
    always_comb
    begin
        if (width_reg == '0)
            eff_width = WIDTH_REG_W'(1);
        else if (width_reg > WIDTH_REG_W'(WIDTH_CAP))
            eff_width = WIDTH_REG_W'(WIDTH_CAP);
        else
            eff_width = width_reg;

        if (height_reg == '0)
            eff_height = HEIGHT_REG_W'(1);
        else if (height_reg > HEIGHT_REG_W'(MAX_HEIGHT))
            eff_height = HEIGHT_REG_W'(MAX_HEIGHT);
        else
            eff_height = height_reg;

        if (chan_cnt_reg == '0)
            eff_ch = CHAN_REG_W'(1);
        else if (chan_cnt_reg > CHAN_REG_W'(MAX_CHANNELS))
            eff_ch = CHAN_REG_W'(MAX_CHANNELS);
        else
            eff_ch = chan_cnt_reg;

        ch_m1 = 2'(eff_ch - CHAN_REG_W'(1));

        case (eff_ch)
            3'd1:    line_len = BC_W'(eff_width);
            3'd2:    line_len = BC_W'(eff_width) << 1;
            3'd3:    line_len = (BC_W'(eff_width) << 1) + BC_W'(eff_width);
            default: line_len = BC_W'(eff_width) << 2;
        endcase
    end

    // Handshakes
    assign s1_fire = s1_valid_reg && (!out_valid_reg || pixel_stream.ready);
    assign byte_stream.ready = !clearing_reg && (!s1_valid_reg || s1_fire);
    assign in_fire = byte_stream.valid && byte_stream.ready;

    // Advance row position for the taken byte
    always_comb
    begin
        bc_chk    = bc_reg;
        row_chk   = row_reg;
        start_chk = at_start_reg;
        if (byte_stream.frame_start)
        begin
            bc_chk    = '0;
            row_chk   = '0;
            start_chk = 1'b1;
        end
        else if (!at_start_reg && (bc_reg >= line_len ||
                 HEIGHT_REG_W'(row_reg) >= eff_height))
        begin
            bc_chk    = '0;
            row_chk   = (HEIGHT_REG_W'(row_reg) + HEIGHT_REG_W'(1) >= eff_height) ?
                        '0 : row_reg + COORD_W'(1);
            start_chk = 1'b1;
        end

        row_wrap = (HEIGHT_REG_W'(row_chk) + HEIGHT_REG_W'(1) >= eff_height) ?
                   '0 : row_chk + COORD_W'(1);
        bc_inc   = bc_chk + BC_W'(1);
        rd_addr  = bc_chk[ADDR_W-1:0];
        in_data  = in_fire && !start_chk;

        // Split byte column into channel and pixel column; divide by three by reciprocal
        bcx   = CALC_W'(bc_chk);
        prod3 = PROD_W'(bcx) * PROD_W'(DIV_MULT);
        q3    = CALC_W'(prod3 >> DIV_SHIFT);
        case (eff_ch)
            3'd1:
            begin
                chan = 2'd0;
                col  = bcx;
            end
            3'd2:
            begin
                chan = {1'b0, bcx[0]};
                col  = bcx >> 1;
            end
            3'd3:
            begin
                chan = 2'(bcx - ((q3 << 1) + q3));
                col  = q3;
            end
            default:
            begin
                chan = bcx[1:0];
                col  = bcx >> 2;
            end
        endcase

        s1_ctrl_next.first    = (bc_chk == '0);
        s1_ctrl_next.row_zero = (row_chk == '0);
        s1_ctrl_next.emit     = (chan == ch_m1);
        s1_ctrl_next.last     = (HEIGHT_REG_W'(row_chk) == eff_height - HEIGHT_REG_W'(1)) &&
                                (col == CALC_W'(eff_width) - CALC_W'(1));
        s1_ctrl_next.chan     = chan;
        s1_ctrl_next.ch_m1    = ch_m1;
        s1_ctrl_next.filter   = filter_reg;
        s1_ctrl_next.row      = row_chk;
        s1_ctrl_next.col      = col[COORD_W-1:0];

        bc_next       = bc_reg;
        row_next      = row_reg;
        at_start_next = at_start_reg;
        filter_next   = filter_reg;
        if (in_fire)
        begin
            if (start_chk)
            begin
                filter_next   = byte_stream.data_byte;
                at_start_next = 1'b0;
                bc_next       = bc_chk;
                row_next      = row_chk;
            end
            else if (bc_inc >= line_len)
            begin
                bc_next       = '0;
                row_next      = row_wrap;
                at_start_next = 1'b1;
            end
            else
            begin
                bc_next  = bc_inc;
                row_next = row_chk;
            end
        end
    end

    // Hold position state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bc_reg       <= '0;
            row_reg      <= '0;
            at_start_reg <= 1'b1;
            filter_reg   <= '0;
        end
        else
        begin
            bc_reg       <= bc_next;
            row_reg      <= row_next;
            at_start_reg <= at_start_next;
            filter_reg   <= filter_next;
        end
    end

    // Sweep the line store to zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            if (clr_cnt_reg == ADDR_W'(STORE_DEPTH - 1))
                clearing_reg <= 1'b0;
        end
    end

    // Track the reconstruct stage occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_data)
            s1_valid_reg <= 1'b1;
        else if (s1_fire)
            s1_valid_reg <= 1'b0;
    end

    // Load stage payload with the data byte
    always_ff @(posedge clk)
    begin
        if (in_data)
        begin
            s1_ctrl_reg <= s1_ctrl_next;
            s1_data_reg <= byte_stream.data_byte;
            s1_addr_reg <= rd_addr;
        end
    end

    // Reconstruct the byte from its neighbors
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            base_left[i]  = s1_ctrl_reg.first ? '0 : left_reg[i];
            base_upper[i] = s1_ctrl_reg.first ? '0 : upper_reg[i];
        end
        base_gather = s1_ctrl_reg.first ? '0 : gather_reg;

        nb_a = base_left[s1_ctrl_reg.ch_m1];
        nb_c = base_upper[s1_ctrl_reg.ch_m1];
        nb_b = s1_ctrl_reg.row_zero ? '0 : rd_data_reg;

        case (s1_ctrl_reg.filter)
            FILTER_SUB:     pred = nb_a;
            FILTER_UP:      pred = nb_b;
            FILTER_AVERAGE: pred = DATA_W'(({1'b0, nb_a} + {1'b0, nb_b}) >> 1);
            FILTER_PAETH:   pred = paeth_predict(nb_a, nb_b, nb_c);
            default:        pred = '0;
        endcase
        rec = s1_data_reg + pred;

        case (s1_ctrl_reg.ch_m1)
            2'd0:    argb_new = {ALPHA_OPAQUE, rec, rec, rec};
            2'd1:    argb_new = {rec, base_gather[23:16], base_gather[23:16],
                                 base_gather[23:16]};
            2'd2:    argb_new = {ALPHA_OPAQUE, base_gather[23:8], rec};
            default: argb_new = {rec, base_gather};
        endcase

        // Drop the gather on a finished pixel, else drop the byte into its slot
        gather_next = base_gather;
        if (s1_ctrl_reg.emit)
            gather_next = '0;
        else
        begin
            case (s1_ctrl_reg.chan)
                2'd0:    gather_next[23:16] = rec;
                2'd1:    gather_next[15:8]  = rec;
                2'd2:    gather_next[7:0]   = rec;
                default: ;
            endcase
        end
    end

    // Shift neighbors and gather pixel channels
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            left_reg[0]  <= rec;
            upper_reg[0] <= nb_b;
            for (int i = 1; i < LANES; i++)
            begin
                left_reg[i]  <= base_left[i-1];
                upper_reg[i] <= base_upper[i-1];
            end
            gather_reg <= gather_next;
        end
    end

    // Line store: one write port, one registered read port
    always_comb
    begin
        mem_we    = clearing_reg || s1_fire;
        mem_waddr = clearing_reg ? clr_cnt_reg : s1_addr_reg;
        mem_wdata = clearing_reg ? '0 : rec;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_waddr] <= mem_wdata;
        if (in_data)
            rd_data_reg <= store_mem[rd_addr];
    end

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire && s1_ctrl_reg.emit)
            out_valid_reg <= 1'b1;
        else if (pixel_stream.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_ctrl_reg.emit)
        begin
            out_argb_reg <= argb_new;
            out_col_reg  <= s1_ctrl_reg.col;
            out_row_reg  <= s1_ctrl_reg.row;
            out_last_reg <= s1_ctrl_reg.last;
        end
    end

    assign pixel_stream.valid         = out_valid_reg;
    assign pixel_stream.argb          = out_argb_reg;
    assign pixel_stream.pixel_column  = out_col_reg;
    assign pixel_stream.pixel_row     = out_row_reg;
    assign pixel_stream.last_of_image = out_last_reg;

    // Checks
    `PNGUF_ASSERT_NOW(a_no_input_while_clearing, clk, rst_n, clearing_reg, !byte_stream.ready, "byte taken during line store sweep")
    `PNGUF_ASSERT_NOW(a_no_same_entry_rw, clk, rst_n, s1_fire && in_data, s1_addr_reg != rd_addr, "line store read and write hit one entry")
    `PNGUF_ASSERT_NOW(a_column_in_row, clk, rst_n, in_data, bc_chk < line_len, "data byte past the row length")
    `PNGUF_ASSERT_NEXT(a_word_from_stage, clk, rst_n, !out_valid_reg && !(s1_fire && s1_ctrl_reg.emit), !out_valid_reg, "pixel word without a finished pixel")

endmodule
